// ----- rtl/core/cpa16_pkg.sv -----
package cpa16_pkg;

    localparam logic [2:0] MODE_ADD = 3'd0;
    localparam logic [2:0] MODE_ADC = 3'd1;
    localparam logic [2:0] MODE_SBC = 3'd2;
    localparam logic [2:0] MODE_INC = 3'd3;
    localparam logic [2:0] MODE_DEC = 3'd4;

    localparam logic [1:0] SEL_BC = 2'd0;
    localparam logic [1:0] SEL_DE = 2'd1;
    localparam logic [1:0] SEL_HL = 2'd2;
    localparam logic [1:0] SEL_SP = 2'd3;

    localparam logic [1:0] PFX_NONE = 2'd0;
    localparam logic [1:0] PFX_IX   = 2'd1;
    localparam logic [1:0] PFX_IY   = 2'd2;

    localparam logic [2:0] REG_BC = 3'd0;
    localparam logic [2:0] REG_DE = 3'd1;
    localparam logic [2:0] REG_HL = 3'd2;
    localparam logic [2:0] REG_SP = 3'd3;
    localparam logic [2:0] REG_IX = 3'd4;
    localparam logic [2:0] REG_IY = 3'd5;

    localparam logic [7:0] F_S          = 8'b1000_0000;
    localparam logic [7:0] F_Z          = 8'b0100_0000;
    localparam logic [7:0] F_H          = 8'b0001_0000;
    localparam logic [7:0] F_PV         = 8'b0000_0100;
    localparam logic [7:0] F_N          = 8'b0000_0010;
    localparam logic [7:0] F_C          = 8'b0000_0001;
    localparam logic [7:0] KEEP_ADD     = 8'b1110_1100;
    localparam logic [7:0] KEEP_ADC_SBC = 8'b0010_1000;

    typedef enum logic [4:0] {
        OP_ADD = 5'b00001,
        OP_ADC = 5'b00010,
        OP_SBC = 5'b00100,
        OP_INC = 5'b01000,
        OP_DEC = 5'b10000
    } t_op;

    typedef struct packed {
        logic [2:0]  mode;
        logic [1:0]  pair_select;
        logic [1:0]  index_prefix;
        logic [15:0] pair_bc;
        logic [15:0] pair_de;
        logic [15:0] pair_hl;
        logic [15:0] stack_pointer;
        logic [15:0] index_x;
        logic [15:0] index_y;
        logic [7:0]  flags_in;
    } t_in_item;

    typedef struct packed {
        logic [15:0] result_value;
        logic [2:0]  target_reg;
        logic [7:0]  flags_out;
        logic        status;
    } t_out_item;

endpackage

// ----- rtl/core/cpu_pair_arith_16bit.sv -----
// Sixteen-bit register-pair arithmetic (ADD, ADC, SBC, INC, DEC) for an
// 8-bit CPU core. busy is never raised, so a new instruction may be started
// in every cycle. Each instruction gives exactly one result, shown for one
// cycle with o_strobe high, once the start transfer has passed decode and
// operand selection, the low twelve bits of the adder, then the top four bits
// with the flag logic. The receiver cannot stall the result. Prefixed INC/DEC
// on a pair other than HL and undefined modes return status 1 with a zero
// result, target 0 and the flags unchanged. Results leave in start order.
module cpu_pair_arith_16bit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  cpa16_pkg::t_in_item   i_item,
    output logic                  o_strobe,
    output cpa16_pkg::t_out_item  o_item
);
    import cpa16_pkg::*;

    // stage 1: decode and operands
    logic        r_s1_valid, n_s1_valid;
    logic [15:0] r_s1_a, n_s1_a;
    logic [15:0] r_s1_b, n_s1_b;
    logic        r_s1_cin, n_s1_cin;
    logic        r_s1_sub, n_s1_sub;
    t_op         r_s1_op, n_s1_op;
    logic [2:0]  r_s1_tgt, n_s1_tgt;
    logic        r_s1_err, n_s1_err;
    logic [7:0]  r_s1_flags;

    // stage 2: low twelve bits
    logic        r_s2_valid;
    logic [11:0] r_s2_lo, n_s2_lo;
    logic        r_s2_c12, n_s2_c12;
    logic [3:0]  r_s2_a_hi;
    logic [3:0]  r_s2_b_hi;
    logic        r_s2_sub;
    t_op         r_s2_op;
    logic [2:0]  r_s2_tgt;
    logic        r_s2_err;
    logic [7:0]  r_s2_flags;

    // stage 3: output register
    logic        r_s3_valid;
    t_out_item   r_s3_item, n_s3_item;

    logic [1:0]  pfx;
    logic [15:0] sel_val;
    logic [15:0] base_val;
    logic [2:0]  base_tgt;
    logic [4:0]  hi_sum;
    logic [15:0] res;
    logic        h_flag;
    logic        c_flag;
    logic        v_flag;

    assign busy = 1'b0;

    always_comb begin
        pfx = (i_item.index_prefix == PFX_IX || i_item.index_prefix == PFX_IY)
            ? i_item.index_prefix : PFX_NONE;
        unique case (i_item.pair_select)
            SEL_BC:  sel_val = i_item.pair_bc;
            SEL_DE:  sel_val = i_item.pair_de;
            SEL_HL:  sel_val = i_item.pair_hl;
            default: sel_val = i_item.stack_pointer;
        endcase
        priority if (pfx == PFX_IX) begin
            base_val = i_item.index_x;
            base_tgt = REG_IX;
        end else if (pfx == PFX_IY) begin
            base_val = i_item.index_y;
            base_tgt = REG_IY;
        end else begin
            base_val = i_item.pair_hl;
            base_tgt = REG_HL;
        end

        n_s1_valid = start & ~busy;
        n_s1_a     = base_val;
        n_s1_b     = sel_val;
        n_s1_cin   = 1'b0;
        n_s1_sub   = 1'b0;
        n_s1_op    = OP_ADD;
        n_s1_tgt   = base_tgt;
        n_s1_err   = 1'b0;
        unique case (i_item.mode)
            MODE_ADD: begin
                n_s1_b = (i_item.pair_select == SEL_HL) ? base_val : sel_val;
            end
            MODE_ADC: begin
                n_s1_op  = OP_ADC;
                n_s1_a   = i_item.pair_hl;
                n_s1_tgt = REG_HL;
                n_s1_cin = i_item.flags_in[0];
            end
            MODE_SBC: begin
                n_s1_op  = OP_SBC;
                n_s1_a   = i_item.pair_hl;
                n_s1_b   = ~sel_val;
                n_s1_tgt = REG_HL;
                n_s1_cin = ~i_item.flags_in[0];
                n_s1_sub = 1'b1;
            end
            MODE_INC, MODE_DEC: begin
                n_s1_op  = (i_item.mode == MODE_INC) ? OP_INC : OP_DEC;
                n_s1_b   = (i_item.mode == MODE_INC) ? 16'h0000 : 16'hFFFF;
                n_s1_cin = (i_item.mode == MODE_INC);
                if (pfx != PFX_NONE && i_item.pair_select != SEL_HL) begin
                    n_s1_err = 1'b1;
                end else if (pfx == PFX_NONE) begin
                    n_s1_a   = sel_val;
                    n_s1_tgt = {1'b0, i_item.pair_select};
                end
            end
            default: begin
                n_s1_err = 1'b1;
            end
        endcase
    end

    always_comb begin
        {n_s2_c12, n_s2_lo} = {1'b0, r_s1_a[11:0]} + {1'b0, r_s1_b[11:0]}
                            + {12'd0, r_s1_cin};
    end

    always_comb begin
        hi_sum = {1'b0, r_s2_a_hi} + {1'b0, r_s2_b_hi} + {4'd0, r_s2_c12};
        res    = {hi_sum[3:0], r_s2_lo};
        h_flag = r_s2_c12 ^ r_s2_sub;
        c_flag = hi_sum[4] ^ r_s2_sub;
        v_flag = ~(r_s2_a_hi[3] ^ r_s2_b_hi[3]) & (r_s2_a_hi[3] ^ res[15]);

        n_s3_item.result_value = res;
        n_s3_item.target_reg   = r_s2_tgt;
        n_s3_item.status       = 1'b0;
        unique case (r_s2_op)
            OP_ADD: begin
                n_s3_item.flags_out = (r_s2_flags & KEEP_ADD)
                                    | (h_flag ? F_H : 8'h00)
                                    | (c_flag ? F_C : 8'h00);
            end
            OP_ADC, OP_SBC: begin
                n_s3_item.flags_out = (r_s2_flags & KEEP_ADC_SBC)
                                    | (res[15] ? F_S : 8'h00)
                                    | ((res == 16'h0000) ? F_Z : 8'h00)
                                    | (h_flag ? F_H : 8'h00)
                                    | (v_flag ? F_PV : 8'h00)
                                    | (r_s2_sub ? F_N : 8'h00)
                                    | (c_flag ? F_C : 8'h00);
            end
            default: begin
                n_s3_item.flags_out = r_s2_flags;
            end
        endcase
        if (r_s2_err) begin
            n_s3_item.result_value = 16'h0000;
            n_s3_item.target_reg   = REG_BC;
            n_s3_item.flags_out    = r_s2_flags;
            n_s3_item.status       = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_a     <= n_s1_a;
        r_s1_b     <= n_s1_b;
        r_s1_cin   <= n_s1_cin;
        r_s1_sub   <= n_s1_sub;
        r_s1_op    <= n_s1_op;
        r_s1_tgt   <= n_s1_tgt;
        r_s1_err   <= n_s1_err;
        r_s1_flags <= i_item.flags_in;

        r_s2_lo    <= n_s2_lo;
        r_s2_c12   <= n_s2_c12;
        r_s2_a_hi  <= r_s1_a[15:12];
        r_s2_b_hi  <= r_s1_b[15:12];
        r_s2_sub   <= r_s1_sub;
        r_s2_op    <= r_s1_op;
        r_s2_tgt   <= r_s1_tgt;
        r_s2_err   <= r_s1_err;
        r_s2_flags <= r_s1_flags;

        r_s3_item  <= n_s3_item;
    end

    assign o_strobe = r_s3_valid;
    assign o_item   = r_s3_item;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##3 o_strobe)
        else $error("transfer did not produce a result after three cycles");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start, 3))
        else $error("result strobe without a matching start");

    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_item.status) |->
            (o_item.result_value == 16'h0000 && o_item.target_reg == REG_BC))
        else $error("failed instruction reports a write");

    a_tgt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_item.target_reg <= REG_IY))
        else $error("target register out of range");

endmodule
